// ===== hw/rtl/nnsi_pkg.sv =====
package nnsi_pkg;

   localparam int NUM_LINES = 32;
   localparam int LINE_W    = 5;
   localparam int ADDR_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam int CODE_W    = 8;

   typedef enum logic [1:0] {
      KIND_SWAP  = 2'd0,
      KIND_GATE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_WALK,
      ST_GATE,
      ST_BACK,
      ST_SINGLE
   } state_type;

   // request to the line permutation tables
   typedef struct packed {
      logic              clear;
      logic [LINE_W-1:0] l2p_rd_a;
      logic [LINE_W-1:0] l2p_rd_b;
      logic [LINE_W-1:0] p2l_rd;
      logic              wr_en;
      logic [LINE_W-1:0] wr_phys;
      logic [LINE_W-1:0] wr_log;
   } perm_req_type;

   typedef struct packed {
      logic [LINE_W-1:0] l2p_a;
      logic [LINE_W-1:0] l2p_b;
      logic [LINE_W-1:0] p2l;
   } perm_rsp_type;

endpackage

// ===== hw/rtl/nnsi_perm_ram.sv =====
module nnsi_perm_ram (
   input  logic                  clock,
   input  logic                  reset,
   input  nnsi_pkg::perm_req_type req,
   output nnsi_pkg::perm_rsp_type rsp
);
   import nnsi_pkg::*;

   logic [LINE_W-1:0] p2l_mem [NUM_LINES];
   logic [LINE_W-1:0] l2p_mem [NUM_LINES];

   // an entry whose valid bit is clear reads as its own index
   logic [NUM_LINES-1:0] p2l_vld_ff, p2l_vld_in;
   logic [NUM_LINES-1:0] l2p_vld_ff, l2p_vld_in;

   logic [LINE_W-1:0] a_mem_ff, b_mem_ff, p_mem_ff;
   logic              a_vld_ff, b_vld_ff, p_vld_ff;
   logic [LINE_W-1:0] a_addr_ff, b_addr_ff, p_addr_ff;

   always_comb begin
      p2l_vld_in = p2l_vld_ff;
      l2p_vld_in = l2p_vld_ff;
      if (req.clear) begin
         p2l_vld_in = '0;
         l2p_vld_in = '0;
      end else if (req.wr_en) begin
         p2l_vld_in[req.wr_phys[ADDR_W-1:0]] = 1'b1;
         l2p_vld_in[req.wr_log[ADDR_W-1:0]]  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2l_vld_ff <= '0;
         l2p_vld_ff <= '0;
      end else begin
         p2l_vld_ff <= p2l_vld_in;
         l2p_vld_ff <= l2p_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         p2l_mem[req.wr_phys[ADDR_W-1:0]] <= req.wr_log;
         l2p_mem[req.wr_log[ADDR_W-1:0]]  <= req.wr_phys;
      end
   end

   always_ff @(posedge clock) begin
      a_mem_ff  <= l2p_mem[req.l2p_rd_a[ADDR_W-1:0]];
      b_mem_ff  <= l2p_mem[req.l2p_rd_b[ADDR_W-1:0]];
      p_mem_ff  <= p2l_mem[req.p2l_rd[ADDR_W-1:0]];
      a_vld_ff  <= l2p_vld_ff[req.l2p_rd_a[ADDR_W-1:0]];
      b_vld_ff  <= l2p_vld_ff[req.l2p_rd_b[ADDR_W-1:0]];
      p_vld_ff  <= p2l_vld_ff[req.p2l_rd[ADDR_W-1:0]];
      a_addr_ff <= req.l2p_rd_a;
      b_addr_ff <= req.l2p_rd_b;
      p_addr_ff <= req.p2l_rd;
   end

   assign rsp.l2p_a = a_vld_ff ? a_mem_ff : a_addr_ff;
   assign rsp.l2p_b = b_vld_ff ? b_mem_ff : b_addr_ff;
   assign rsp.p2l   = p_vld_ff ? p_mem_ff : p_addr_ff;

endmodule

// ===== hw/rtl/nearest_neighbour_swap_inserter.sv =====
// Swap inserter for a linear line layout. Each accepted word is one gate; the
// block answers with a run of words: adjacent-line swaps that walk the target
// next to its control, the moved gate, and in naive mode (csr reorder bit 0)
// the same swaps in reverse. With the reorder bit set it keeps a
// logical/physical line permutation in two small tables, maps gate lines
// through it and updates it on each swap. rsp_last marks the final word of a
// gate. One gate is handled at a time and req_stall is high while it is in
// work: a decode state and a table lookup state, then one result word per
// cycle out of the output register while rsp_stall does not hold it.
// Pass-through and error gates skip the lookup state. The next gate is
// taken as soon as req_stall drops. The permutation is identity after reset
// and after a gate with req_new_circuit set, with no clearing pass.
module nearest_neighbour_swap_inserter (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_new_circuit,
   input  logic                          req_pass_through,
   input  logic                          req_too_many_controls,
   input  logic                          req_has_control,
   input  logic [nnsi_pkg::LINE_W-1:0]   req_control_line,
   input  logic [nnsi_pkg::LINE_W-1:0]   req_target_line,
   input  logic [nnsi_pkg::CODE_W-1:0]   req_gate_code,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_result_kind,
   output logic [nnsi_pkg::LINE_W-1:0]   rsp_line_a,
   output logic [nnsi_pkg::LINE_W-1:0]   rsp_line_b,
   output logic                          rsp_out_has_control,
   output logic [nnsi_pkg::CODE_W-1:0]   rsp_out_gate_code,
   output logic                          rsp_last
);
   import nnsi_pkg::*;

   state_type state_ff, state_in;

   logic reorder_ff;

   logic              pt_ff, tmc_ff, hc_ff;
   logic [LINE_W-1:0] ctl_ff, tgt_ff;
   logic [CODE_W-1:0] code_ff;

   logic [LINE_W-1:0] t_ff, t_in;
   logic [LINE_W-1:0] c_ff, c_in;
   logic              down_ff, down_in;
   logic [LINE_W-1:0] cnt_ff, cnt_in;
   logic [LINE_W-1:0] dist_ff, dist_in;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff, kind_in;
   logic [LINE_W-1:0] line_a_ff, line_a_in;
   logic [LINE_W-1:0] line_b_ff, line_b_in;
   logic              ohc_ff, ohc_in;
   logic [CODE_W-1:0] ocode_ff, ocode_in;
   logic              last_ff, last_in;

   perm_req_type perm_req;
   perm_rsp_type perm_rsp;

   logic              accept;
   logic              out_free;
   logic              emit;
   logic              bad_gate;
   logic [LINE_W-1:0] t_sel, c_sel, diff, dist_sel;
   logic              down_sel;
   logic [LINE_W-1:0] walk_nxt, back_nxt;

   nnsi_perm_ram u_perm (
      .clock (clock),
      .reset (reset),
      .req   (perm_req),
      .rsp   (perm_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign bad_gate = tmc_ff
                   || ({1'b0, tgt_ff} >= (LINE_W+1)'(NUM_LINES))
                   || (hc_ff && (({1'b0, ctl_ff} >= (LINE_W+1)'(NUM_LINES))
                                 || (ctl_ff == tgt_ff)));

   // physical lines once the table lookup has returned
   assign t_sel    = reorder_ff ? perm_rsp.l2p_a : tgt_ff;
   assign c_sel    = reorder_ff ? perm_rsp.l2p_b : ctl_ff;
   assign down_sel = (t_sel > c_sel);
   assign diff     = down_sel ? (t_sel - c_sel) : (c_sel - t_sel);
   assign dist_sel = diff - LINE_W'(1);

   assign walk_nxt = down_ff ? (t_ff - LINE_W'(1)) : (t_ff + LINE_W'(1));
   assign back_nxt = down_ff ? (t_ff + LINE_W'(1)) : (t_ff - LINE_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (pt_ff || bad_gate) state_in = ST_SINGLE;
            else                   state_in = ST_LOAD;
         end
         ST_LOAD: begin
            priority if (!hc_ff)              state_in = ST_SINGLE;
            else if (dist_sel == '0)          state_in = ST_GATE;
            else                              state_in = ST_WALK;
         end
         ST_WALK: begin
            if (out_free && cnt_ff == LINE_W'(1)) state_in = ST_GATE;
         end
         ST_GATE: begin
            if (out_free) begin
               if (reorder_ff || dist_ff == '0) state_in = ST_IDLE;
               else                             state_in = ST_BACK;
            end
         end
         ST_BACK: begin
            if (out_free && cnt_ff == LINE_W'(1)) state_in = ST_IDLE;
         end
         ST_SINGLE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result words
   always_comb begin
      emit      = 1'b0;
      kind_in   = KIND_SWAP;
      line_a_in = '0;
      line_b_in = '0;
      ohc_in    = 1'b0;
      ocode_in  = '0;
      last_in   = 1'b0;
      t_in      = t_ff;
      c_in      = c_ff;
      down_in   = down_ff;
      cnt_in    = cnt_ff;
      dist_in   = dist_ff;

      perm_req.clear    = accept && req_new_circuit;
      perm_req.l2p_rd_a = tgt_ff;
      perm_req.l2p_rd_b = ctl_ff;
      perm_req.p2l_rd   = walk_nxt;
      perm_req.wr_en    = 1'b0;
      perm_req.wr_phys  = t_ff;
      perm_req.wr_log   = perm_rsp.p2l;

      unique case (state_ff)
         ST_LOAD: begin
            t_in    = t_sel;
            c_in    = c_sel;
            down_in = down_sel;
            cnt_in  = dist_sel;
            dist_in = dist_sel;
            perm_req.p2l_rd = down_sel ? (t_sel - LINE_W'(1)) : (t_sel + LINE_W'(1));
         end
         ST_WALK: begin
            if (out_free) begin
               emit      = 1'b1;
               kind_in   = KIND_SWAP;
               line_a_in = t_ff;
               line_b_in = walk_nxt;
               t_in      = walk_nxt;
               cnt_in    = cnt_ff - LINE_W'(1);
               // the neighbor's logical line moves into our old place
               perm_req.wr_en  = reorder_ff;
               perm_req.p2l_rd = down_ff ? (t_ff - LINE_W'(2)) : (t_ff + LINE_W'(2));
            end
         end
         ST_GATE: begin
            if (out_free) begin
               emit      = 1'b1;
               kind_in   = KIND_GATE;
               line_a_in = t_ff;
               line_b_in = c_ff;
               ohc_in    = 1'b1;
               ocode_in  = code_ff;
               last_in   = reorder_ff || dist_ff == '0;
               cnt_in    = dist_ff;
               // settle the target's own entry at its final place
               perm_req.wr_en  = reorder_ff;
               perm_req.wr_log = tgt_ff;
            end
         end
         ST_BACK: begin
            if (out_free) begin
               emit      = 1'b1;
               kind_in   = KIND_SWAP;
               line_a_in = t_ff;
               line_b_in = back_nxt;
               last_in   = (cnt_ff == LINE_W'(1));
               t_in      = back_nxt;
               cnt_in    = cnt_ff - LINE_W'(1);
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               emit    = 1'b1;
               last_in = 1'b1;
               priority if (pt_ff) begin
                  kind_in   = KIND_GATE;
                  line_a_in = tgt_ff;
                  line_b_in = hc_ff ? ctl_ff : '0;
                  ohc_in    = hc_ff;
                  ocode_in  = code_ff;
               end else if (bad_gate) begin
                  kind_in = KIND_ERROR;
               end else begin
                  kind_in   = KIND_GATE;
                  line_a_in = t_ff;
                  ocode_in  = code_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      priority if (emit)  rsp_valid_in = 1'b1;
      else if (out_free)  rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         reorder_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) reorder_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pt_ff   <= req_pass_through;
         tmc_ff  <= req_too_many_controls;
         hc_ff   <= req_has_control;
         ctl_ff  <= req_control_line;
         tgt_ff  <= req_target_line;
         code_ff <= req_gate_code;
      end
      t_ff    <= t_in;
      c_ff    <= c_in;
      down_ff <= down_in;
      cnt_ff  <= cnt_in;
      dist_ff <= dist_in;
      if (emit) begin
         kind_ff   <= kind_in;
         line_a_ff <= line_a_in;
         line_b_ff <= line_b_in;
         ohc_ff    <= ohc_in;
         ocode_ff  <= ocode_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_line_a          = line_a_ff;
   assign rsp_line_b          = line_b_ff;
   assign rsp_out_has_control = ohc_ff;
   assign rsp_out_gate_code   = ocode_ff;
   assign rsp_last            = last_ff;

endmodule

// ===== sim/swap_stream_checker.sv =====
`timescale 1ns / 100ps

module swap_stream_checker (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data,

   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_new_circuit,
   input  logic                        req_pass_through,
   input  logic                        req_too_many_controls,
   input  logic                        req_has_control,
   input  logic [nnsi_pkg::LINE_W-1:0] req_control_line,
   input  logic [nnsi_pkg::LINE_W-1:0] req_target_line,
   input  logic [nnsi_pkg::CODE_W-1:0] req_gate_code,

   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [1:0]                  rsp_result_kind,
   input  logic [nnsi_pkg::LINE_W-1:0] rsp_line_a,
   input  logic [nnsi_pkg::LINE_W-1:0] rsp_line_b,
   input  logic                        rsp_out_has_control,
   input  logic [nnsi_pkg::CODE_W-1:0] rsp_out_gate_code,
   input  logic                        rsp_last,

   output int                          mismatch_count,
   output int                          words_outstanding
);
   import nnsi_pkg::*;

   localparam int TABLE_DEPTH = 1 << LINE_W;

   typedef struct {
      kind_type          kind;
      logic [LINE_W-1:0] line_a;
      logic [LINE_W-1:0] line_b;
      logic              has_control;
      logic [CODE_W-1:0] gate_code;
      logic              last;
   } layout_word_type;

   layout_word_type   predicted_words[$];
   logic [LINE_W-1:0] phys_to_log [TABLE_DEPTH];
   logic [LINE_W-1:0] log_to_phys [TABLE_DEPTH];
   logic              reorder;
   int                fails = 0;

   function automatic void restore_identity();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         phys_to_log[i] = LINE_W'(i);
         log_to_phys[i] = LINE_W'(i);
      end
   endfunction

   function automatic void exchange_lines(int p, int q);
      logic [LINE_W-1:0] lp;
      logic [LINE_W-1:0] lq;
      lp = phys_to_log[p];
      lq = phys_to_log[q];
      phys_to_log[p] = lq;
      phys_to_log[q] = lp;
      log_to_phys[lq] = LINE_W'(p);
      log_to_phys[lp] = LINE_W'(q);
   endfunction

   function automatic void push_word(kind_type kind, int a, int b, logic hc,
                                     logic [CODE_W-1:0] code);
      layout_word_type w;
      w.kind        = kind;
      w.line_a      = LINE_W'(a);
      w.line_b      = LINE_W'(b);
      w.has_control = hc;
      w.gate_code   = code;
      w.last        = 1'b0;
      predicted_words.insert(predicted_words.size(), w);
   endfunction

   task automatic insert_swaps(logic nc, logic pt, logic tmc, logic hc,
                               logic [LINE_W-1:0] ctl, logic [LINE_W-1:0] tgt,
                               logic [CODE_W-1:0] code);
      int t;
      int c;
      int step;
      int span;
      if (nc)
         restore_identity();
      if (pt) begin
         push_word(KIND_GATE, int'(tgt), hc ? int'(ctl) : 0, hc, code);
      end else if (tmc || tgt >= NUM_LINES || (hc && (ctl >= NUM_LINES || ctl == tgt))) begin
         push_word(KIND_ERROR, 0, 0, 1'b0, '0);
      end else begin
         t = reorder ? int'(log_to_phys[tgt]) : int'(tgt);
         if (!hc) begin
            push_word(KIND_GATE, t, 0, 1'b0, code);
         end else begin
            c = reorder ? int'(log_to_phys[ctl]) : int'(ctl);
            step = (t > c) ? -1 : 1;
            span = (t > c) ? t - c - 1 : c - t - 1;
            // walk the target toward its control
            for (int i = 0; i < span; i++) begin
               push_word(KIND_SWAP, t, t + step, 1'b0, '0);
               if (reorder)
                  exchange_lines(t, t + step);
               t += step;
            end
            push_word(KIND_GATE, t, c, 1'b1, code);
            // naive mode: walk back to restore the layout
            if (!reorder) begin
               for (int i = 0; i < span; i++) begin
                  push_word(KIND_SWAP, t, t - step, 1'b0, '0);
                  t -= step;
               end
            end
         end
      end
      predicted_words[predicted_words.size() - 1].last = 1'b1;
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   task automatic compare_word();
      layout_word_type want_word;
      if (predicted_words.size() == 0) begin
         $error("result word with no prediction pending: kind %0d line_a %0d line_b %0d",
                rsp_result_kind, rsp_line_a, rsp_line_b);
         fails++;
      end else begin
         want_word = predicted_words.pop_front();
         check_field("result_kind", 32'(want_word.kind), 32'(rsp_result_kind));
         check_field("line_a", 32'(want_word.line_a), 32'(rsp_line_a));
         check_field("line_b", 32'(want_word.line_b), 32'(rsp_line_b));
         check_field("out_has_control", 32'(want_word.has_control),
                     32'(rsp_out_has_control));
         check_field("out_gate_code", 32'(want_word.gate_code), 32'(rsp_out_gate_code));
         check_field("last", 32'(want_word.last), 32'(rsp_last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_identity();
         reorder = 1'b0;
         predicted_words.delete();
      end else begin
         if (csr_wr_en)
            reorder = csr_wr_data;
         if (req_valid && !req_stall)
            insert_swaps(req_new_circuit, req_pass_through, req_too_many_controls,
                         req_has_control, req_control_line, req_target_line,
                         req_gate_code);
         if (rsp_valid && !rsp_stall)
            compare_word();
      end
      mismatch_count    <= fails;
      words_outstanding <= predicted_words.size();
   end

endmodule

// ===== sim/tb_nearest_neighbour_swap_inserter.sv =====
`timescale 1ns / 100ps

module tb_nearest_neighbour_swap_inserter;
   import nnsi_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   // longest gate: 30 swaps out and back plus decode
   localparam int SETTLE_CYCLES = 70;
   localparam int PHASES        = 8;
   localparam int GATES_PER_PHASE = 50;

   typedef struct packed {
      logic              new_circuit;
      logic              pass_through;
      logic              too_many_controls;
      logic              has_control;
      logic [LINE_W-1:0] control_line;
      logic [LINE_W-1:0] tgt_line;
      logic [CODE_W-1:0] gate_code;
   } gate_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic              csr_wr_data;
   logic              req_valid;
   logic              req_stall;
   logic              req_new_circuit;
   logic              req_pass_through;
   logic              req_too_many_controls;
   logic              req_has_control;
   logic [LINE_W-1:0] req_control_line;
   logic [LINE_W-1:0] req_target_line;
   logic [CODE_W-1:0] req_gate_code;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_result_kind;
   logic [LINE_W-1:0] rsp_line_a;
   logic [LINE_W-1:0] rsp_line_b;
   logic              rsp_out_has_control;
   logic [CODE_W-1:0] rsp_out_gate_code;
   logic              rsp_last;

   int mismatch_count;
   int words_outstanding;
   int sender_idle_pct;
   int receiver_stall_pct;
   int cycle_count = 0;

   nearest_neighbour_swap_inserter uut (.*);

   swap_stream_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

   function automatic gate_type make_gate(logic nc, logic pt, logic tmc, logic hc,
                                          int ctl, int tgt, int code);
      gate_type g;
      g.new_circuit       = nc;
      g.pass_through      = pt;
      g.too_many_controls = tmc;
      g.has_control       = hc;
      g.control_line      = LINE_W'(ctl);
      g.tgt_line          = LINE_W'(tgt);
      g.gate_code         = CODE_W'(code);
      return g;
   endfunction

   function automatic gate_type random_gate();
      gate_type g;
      int       pick;
      g = make_gate($urandom_range(99) < 4, 1'b0, 1'b0, 1'b1,
                    $urandom, $urandom, $urandom);
      pick = $urandom_range(99);
      if (pick < 6) begin
         g.pass_through      = 1'b1;
         g.too_many_controls = 1'($urandom_range(1));
         g.has_control       = 1'($urandom_range(1));
      end else if (pick < 11) begin
         g.too_many_controls = 1'b1;
         g.has_control       = 1'($urandom_range(1));
      end else if (pick < 16) begin
         g.control_line = g.tgt_line;
      end else if (pick < 28) begin
         g.has_control = 1'b0;
      end else begin
         while (g.control_line == g.tgt_line)
            g.control_line = LINE_W'($urandom);
      end
      return g;
   endfunction

   task automatic send_gate(gate_type g);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_new_circuit       <= g.new_circuit;
      req_pass_through      <= g.pass_through;
      req_too_many_controls <= g.too_many_controls;
      req_has_control       <= g.has_control;
      req_control_line      <= g.control_line;
      req_target_line       <= g.tgt_line;
      req_gate_code         <= g.gate_code;
      do @(posedge clock); while (req_stall);
   endtask

   // hold the sender until every predicted word has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_mode(logic reorder_on);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= reorder_on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_directed();
      send_gate(make_gate(1, 0, 0, 1, 31, 0, 8'hFF));
      send_gate(make_gate(0, 0, 0, 1, 0, 31, 8'h00));
      send_gate(make_gate(0, 0, 0, 0, 0, 31, 8'h3C));
      send_gate(make_gate(0, 0, 0, 1, 6, 5, 8'h81));
      send_gate(make_gate(0, 0, 0, 1, 12, 12, 8'h42));
      send_gate(make_gate(0, 0, 1, 1, 2, 9, 8'h55));
      // pass-through wins over every error condition
      send_gate(make_gate(0, 1, 1, 1, 7, 7, 8'hA5));
      send_gate(make_gate(0, 1, 0, 0, 31, 0, 8'h5A));
      send_gate(make_gate(1, 0, 1, 0, 0, 0, 8'h01));
      send_gate(make_gate(0, 0, 0, 1, 20, 3, 8'hC3));
      send_gate(make_gate(0, 0, 0, 0, 0, 3, 8'h18));
      send_gate(make_gate(1, 1, 0, 1, 1, 30, 8'hE7));
   endtask

   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = 1'b0;
      req_valid             = 1'b0;
      req_new_circuit       = 1'b0;
      req_pass_through      = 1'b0;
      req_too_many_controls = 1'b0;
      req_has_control       = 1'b0;
      req_control_line      = '0;
      req_target_line       = '0;
      req_gate_code         = '0;
      sender_idle_pct       = 0;
      receiver_stall_pct    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      settle();
      program_mode(1'b1);
      run_directed();
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin
               sender_idle_pct = 0;  receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 48; receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;  receiver_stall_pct = 48;
            end
            default: begin
               sender_idle_pct = 14; receiver_stall_pct = 14;
            end
         endcase
         // cover every idling pattern in both modes
         program_mode(1'((phase ^ (phase >> 2)) & 1));
         for (int n = 0; n < GATES_PER_PHASE; n++)
            send_gate(random_gate());
         settle();
      end

      if (mismatch_count == 0 && words_outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
